/* design/pru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter package
// Shared field widths, filter codes, register indexes and the item that moves
// from the request stage to the reconstruction stage.
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int DATA_W        = 8;
   localparam int COL_W         = 13;
   localparam int ROW_BYTES_W   = 14;
   localparam int PIXEL_BYTES_W = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 14;
   localparam int REQ_DATA_W    = 8;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_DATA_W    = 24;
   localparam int RSP_PAD_W     = RSP_DATA_W - COL_W - DATA_W;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_BYTES   = 1'b0,
      CSR_PIXEL_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [COL_W-1:0]  column;
      filter_type        filter;
      logic              first_row;
      logic              has_left;
      logic              row_end;
   } item_type;

endpackage

/* design/pru_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pru_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter request stage
// Holds the configuration registers, parses filter bytes, tracks the column
// and loads data bytes into the stage register while the line store is read.
// ----------------------------------------------------------------------------
module pru_ctrl #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8,
   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pru_pkg::DATA_W-1:0]          req_data,
   input  logic                                req_start,
   input  logic                                advance,
   output logic                                s1_valid,
   output pru_pkg::item_type                   s1_item,
   output logic [ADDR_W-1:0]                   s1_addr,
   output logic                                rd_en,
   output logic [ADDR_W-1:0]                   rd_addr,
   output logic [pru_pkg::PIXEL_BYTES_W-1:0]   bpp
);
   import pru_pkg::*;

   localparam int LEN_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int EXT_W = (LEN_W > ROW_BYTES_W) ? LEN_W : ROW_BYTES_W;
   localparam int HL_W  = (ADDR_W > PIXEL_BYTES_W) ? ADDR_W : PIXEL_BYTES_W;

   logic [ROW_BYTES_W-1:0]   row_bytes_ff;
   logic [PIXEL_BYTES_W-1:0] pixel_bytes_ff;
   logic [ADDR_W-1:0]        col_ff, col_in;
   filter_type               filter_ff, filter_in;
   logic                     expect_ff, expect_in;
   logic                     first_ff, first_in;
   logic                     s1_valid_ff, s1_valid_in;
   item_type                 s1_item_ff, s1_item_in;
   logic [ADDR_W-1:0]        s1_addr_ff, s1_addr_in;

   logic [EXT_W-1:0]  rb_ext;
   logic [LEN_W-1:0]  row_len;
   logic [LEN_W:0]    col_inc;
   logic              last_byte;
   logic              has_left;
   logic              fire;
   logic              is_filter;
   filter_type        filter_code;

   // Effective row length: zero acts as one, larger values saturate.
   always_comb begin
      rb_ext = EXT_W'(row_bytes_ff);
      if (rb_ext == '0) begin
         row_len = LEN_W'(1);
      end else if (rb_ext > EXT_W'(MAX_ROW_BYTES)) begin
         row_len = LEN_W'(MAX_ROW_BYTES);
      end else begin
         row_len = LEN_W'(rb_ext);
      end
   end

   always_comb begin
      if (pixel_bytes_ff == '0) begin
         bpp = PIXEL_BYTES_W'(1);
      end else if (pixel_bytes_ff > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
         bpp = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp = pixel_bytes_ff;
      end
   end

   assign col_inc   = (LEN_W + 1)'(col_ff) + (LEN_W + 1)'(1);
   assign last_byte = col_inc >= (LEN_W + 1)'(row_len);
   assign has_left  = HL_W'(col_ff) >= HL_W'(bpp);

   // Filter types above Paeth are kept as None.
   assign filter_code = (req_data <= DATA_W'(FILT_PAETH)) ?
                        filter_type'(req_data[2:0]) : FILT_NONE;

   assign req_ready = !s1_valid_ff || advance;
   assign fire      = req_valid && req_ready;
   assign is_filter = req_start || expect_ff;
   assign rd_en     = fire && !is_filter;
   assign rd_addr   = col_ff;

   always_comb begin
      col_in      = col_ff;
      filter_in   = filter_ff;
      expect_in   = expect_ff;
      first_in    = first_ff;
      s1_valid_in = advance ? 1'b0 : s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_addr_in  = s1_addr_ff;
      if (fire) begin
         if (is_filter) begin
            filter_in = filter_code;
            col_in    = '0;
            expect_in = 1'b0;
            if (req_start) begin
               first_in = 1'b1;
            end
         end else begin
            s1_valid_in          = 1'b1;
            s1_item_in.data      = req_data;
            s1_item_in.column    = COL_W'(col_ff);
            s1_item_in.filter    = filter_ff;
            s1_item_in.first_row = first_ff;
            s1_item_in.has_left  = has_left;
            s1_item_in.row_end   = last_byte;
            s1_addr_in           = col_ff;
            if (last_byte) begin
               col_in    = '0;
               expect_in = 1'b1;
               first_in  = 1'b0;
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= ROW_BYTES_W'(1);
         pixel_bytes_ff <= PIXEL_BYTES_W'(1);
         col_ff         <= '0;
         filter_ff      <= FILT_NONE;
         expect_ff      <= 1'b1;
         first_ff       <= 1'b1;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_BYTES: begin
                  row_bytes_ff <= csr_wdata[ROW_BYTES_W-1:0];
               end
               CSR_PIXEL_BYTES: begin
                  pixel_bytes_ff <= csr_wdata[PIXEL_BYTES_W-1:0];
               end
               default: begin
               end
            endcase
         end
         col_ff      <= col_in;
         filter_ff   <= filter_in;
         expect_ff   <= expect_in;
         first_ff    <= first_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
      s1_addr_ff <= s1_addr_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;
   assign s1_addr  = s1_addr_ff;

endmodule

/* design/pru_recon.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter reconstruction stage
// Forms the predictor from the left, upper and upper-left bytes, adds it to
// the filtered byte and holds the result in the output register.
// ----------------------------------------------------------------------------
module pru_recon #(
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               s1_valid,
   input  pru_pkg::item_type                  s1_item,
   input  logic [pru_pkg::DATA_W-1:0]         prior_byte,
   input  logic [pru_pkg::PIXEL_BYTES_W-1:0]  bpp,
   input  logic                               rsp_ready,
   output logic                               advance,
   output logic [pru_pkg::DATA_W-1:0]         wr_byte,
   output logic                               rsp_valid,
   output logic [pru_pkg::DATA_W-1:0]         rsp_pixel,
   output logic [pru_pkg::COL_W-1:0]          rsp_column,
   output logic                               rsp_last
);
   import pru_pkg::*;

   localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [DATA_W-1:0] left_ff  [MAX_PIXEL_BYTES];
   logic [DATA_W-1:0] upper_ff [MAX_PIXEL_BYTES];
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_pixel_ff;
   logic [COL_W-1:0]  out_column_ff;
   logic              out_last_ff;

   logic [IDX_W-1:0]  idx;
   logic [DATA_W-1:0] a, b, c;
   logic [DATA_W:0]   avg_sum;
   logic [DATA_W-1:0] da, db;
   logic [DATA_W+1:0] p_ab, p_cc, dc;
   logic [DATA_W-1:0] paeth;
   logic [DATA_W-1:0] pred;

   assign idx = IDX_W'(bpp - PIXEL_BYTES_W'(1));
   assign b   = s1_item.first_row ? '0 : prior_byte;
   assign a   = s1_item.has_left ? left_ff[idx]  : '0;
   assign c   = s1_item.has_left ? upper_ff[idx] : '0;

   // Paeth distances without forming p: |p-a| = |b-c|, |p-b| = |a-c|,
   // |p-c| = |a+b-2c|. Ties go to a, then b.
   always_comb begin
      da   = (b >= c) ? b - c : c - b;
      db   = (a >= c) ? a - c : c - a;
      p_ab = (DATA_W + 2)'(a) + (DATA_W + 2)'(b);
      p_cc = {1'b0, c, 1'b0};
      dc   = (p_ab >= p_cc) ? p_ab - p_cc : p_cc - p_ab;
      if (((DATA_W + 2)'(da) <= (DATA_W + 2)'(db)) && ((DATA_W + 2)'(da) <= dc)) begin
         paeth = a;
      end else if ((DATA_W + 2)'(db) <= dc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   end

   assign avg_sum = (DATA_W + 1)'(a) + (DATA_W + 1)'(b);

   always_comb begin
      case (s1_item.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[DATA_W:1];
         FILT_PAETH: pred = paeth;
         default:    pred = '0;
      endcase
   end

   assign wr_byte = s1_item.data + pred;
   assign advance = s1_valid && (!out_valid_ff || rsp_ready);

   // The windows are read only once this row has filled them up to the
   // pixel distance, so they need no clearing at a row start.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_ff[i]  <= left_ff[i-1];
            upper_ff[i] <= upper_ff[i-1];
         end
         left_ff[0]    <= wr_byte;
         upper_ff[0]   <= b;
         out_pixel_ff  <= wr_byte;
         out_column_ff <= s1_item.column;
         out_last_ff   <= s1_item.row_end;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_pixel  = out_pixel_ff;
   assign rsp_column = out_column_ff;
   assign rsp_last   = out_last_ff;

endmodule

/* design/png_row_unfilter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter
// Reconstructs raw scanline bytes from the inflated PNG stream, one byte per
// clock while responses are taken, keeping the previous row in a line store.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one stream byte per request, with image_start
//   in req_tuser on the filter byte that opens an image. The first byte of
//   every row is the filter type and produces no response; each following
//   byte yields one response with the raw byte, its column and rsp_tlast on
//   the last byte of the row.
//   Data requests pass through the stage register and the output register,
//   which drives rsp_tvalid. One request is taken every cycle while responses
//   are taken: the line store read is issued at acceptance and reconstruction
//   runs in the following cycle against the left-neighbour window registers.
//   The user writes row_bytes and pixel_bytes only while idle; the block does not check.
//   Reset empties both stages, returns the registers to one byte and expects
//   a filter byte of a first row. The line store is not cleared.
//   When the receiver holds rsp_tready low the response stays in the output
//   register; one more request is taken into the stage register, after which
//   req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module png_row_unfilter #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pru_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic [pru_pkg::REQ_USER_W-1:0]    req_tuser,   // [0] image_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pru_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] pixel_byte, [20:8] column
   output logic                              rsp_tlast,   // row_end
   input  logic                              csr_we,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pru_pkg::*;

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic                     advance;
   logic                     s1_valid;
   item_type                 s1_item;
   logic [ADDR_W-1:0]        s1_addr;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        prior_byte;
   logic [DATA_W-1:0]        wr_byte;
   logic [PIXEL_BYTES_W-1:0] bpp;
   logic [DATA_W-1:0]        rsp_pixel;
   logic [COL_W-1:0]         rsp_column;

   pru_ctrl #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_data  (req_tdata[DATA_W-1:0]),
      .req_start (req_tuser[0]),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_addr   (s1_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .bpp       (bpp)
   );

   pru_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_addr),
      .wr_data (wr_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prior_byte)
   );

   pru_recon #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .prior_byte (prior_byte),
      .bpp        (bpp),
      .rsp_ready  (rsp_tready),
      .advance    (advance),
      .wr_byte    (wr_byte),
      .rsp_valid  (rsp_tvalid),
      .rsp_pixel  (rsp_pixel),
      .rsp_column (rsp_column),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_column, rsp_pixel};

endmodule

/* design/pru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter checker
// Port-level checks on the response channel and flow control, bound to the
// top level.
// ----------------------------------------------------------------------------
module pru_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pru_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);
   import pru_pkg::*;

   logic last_end_ff;

   // The first response after reset, and the first after a row end, is
   // column zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_end_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         last_end_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output register");

   a_row_start_column: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && last_end_ff |-> rsp_tdata[DATA_W +: COL_W] == '0)
      else $error("row does not start at column zero");

   a_req_idle_ok: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid)
      else $error("request stalled without a pending response");

endmodule

bind png_row_unfilter pru_checker u_pru_checker (.*);

/* bench/png_row_unfilter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row unfilter testbench
// Drives the inflated scanline stream into png_row_unfilter with random gaps
// on the request side and random stalls on the response side, predicts each
// raw byte with a local unfilter model or the script; checks each response in order.
// A short scripted bring-up is followed by a partial row under oversized
// register values and a series of randomly configured phases with mostly
// well-formed rows.
// ----------------------------------------------------------------------------
module png_row_unfilter_tb;
   import pru_pkg::*;

   localparam int STORE_DEPTH       = 8192;
   localparam int WINDOW_DEPTH      = 8;
   localparam int DRAIN_CYCLES      = 8;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int RANDOM_PHASES     = 12;
   localparam int PHASE_REQUESTS    = 150;
   localparam int SCRIPT_STEPS      = 23;
   localparam int OVERSIZE_REQUESTS = 48;

   typedef struct packed {
      logic [DATA_W-1:0] pixel;
      logic [COL_W-1:0]  column;
      logic              row_end;
   } unfiltered_byte_type;

   typedef enum logic [1:0] {
      STEP_SEND,
      STEP_SEND_KNOWN,
      STEP_WRITE
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] value;
      logic                  start;
      logic [DATA_W-1:0]     e_pixel;
      logic [COL_W-1:0]      e_column;
      logic                  e_end;
   } script_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_ROW_BYTES;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Unfilter model state.
   logic [DATA_W-1:0] line_store [STORE_DEPTH];
   logic [DATA_W-1:0] left_win [WINDOW_DEPTH];
   logic [DATA_W-1:0] up_left_win [WINDOW_DEPTH];
   int unsigned col_pos;
   filter_type cur_filter;
   bit want_filter;
   bit top_row;
   int unsigned store_fill;
   logic [ROW_BYTES_W-1:0] cfg_row_bytes;
   logic [PIXEL_BYTES_W-1:0] cfg_pixel_bytes;

   unfiltered_byte_type expected_pixels [$];
   int error_count = 0;
   int quiet_cycles = 0;
   int rsp_hold = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   logic [DATA_W-1:0] corner_bytes [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

   // Bring-up: reset registers first (one-byte rows), then four-byte rows of
   // two-byte pixels through every filter, an unknown filter and an image
   // start that cuts a row short.
   script_step_type bringup_script [SCRIPT_STEPS] = '{
      '{STEP_SEND,       CSR_ROW_BYTES,   14'(FILT_NONE),  1'b1, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h0FF,         1'b0, 8'hFF, 13'd0, 1'b1},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'(FILT_UP),    1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h001,         1'b0, 8'h00, 13'd0, 1'b1},
      '{STEP_WRITE,      CSR_ROW_BYTES,   14'd4,           1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_WRITE,      CSR_PIXEL_BYTES, 14'd2,           1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'(FILT_AVG),   1'b1, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h080,         1'b0, 8'h80, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h010,         1'b0, 8'h10, 13'd1, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h001,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h0FF,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'(FILT_PAETH), 1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h000,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h000,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h000,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h000,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h0FF,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h05A,         1'b0, 8'h5A, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'(FILT_SUB),   1'b1, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h0FF,         1'b0, 8'hFF, 13'd0, 1'b0},
      '{STEP_SEND_KNOWN, CSR_ROW_BYTES,   14'h001,         1'b0, 8'h01, 13'd1, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h002,         1'b0, 8'h00, 13'd0, 1'b0},
      '{STEP_SEND,       CSR_ROW_BYTES,   14'h003,         1'b0, 8'h00, 13'd0, 1'b0}
   };

   png_row_unfilter #(
      .MAX_ROW_BYTES  (STORE_DEPTH),
      .MAX_PIXEL_BYTES(WINDOW_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int idle_gap(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] pick_byte();
      if ($urandom_range(0, 99) < 30) return corner_bytes[$urandom_range(0, 5)];
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   // Paeth predictor with the usual tie order: left, then up, then up-left.
   function automatic logic [DATA_W-1:0] paeth_pick(logic [DATA_W-1:0] a,
                                                    logic [DATA_W-1:0] b,
                                                    logic [DATA_W-1:0] c);
      int p, da, db, dc;
      p  = int'(a) + int'(b) - int'(c);
      da = magnitude(p - int'(a));
      db = magnitude(p - int'(b));
      dc = magnitude(p - int'(c));
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   function automatic int unsigned row_len();
      if (cfg_row_bytes == 0) return 1;
      if (cfg_row_bytes > STORE_DEPTH) return STORE_DEPTH;
      return cfg_row_bytes;
   endfunction

   function automatic int unsigned pixel_len();
      if (cfg_pixel_bytes == 0) return 1;
      if (cfg_pixel_bytes > WINDOW_DEPTH) return WINDOW_DEPTH;
      return cfg_pixel_bytes;
   endfunction

   task automatic reset_model();
      cfg_row_bytes = 1;
      cfg_pixel_bytes = 1;
      left_win = '{default: '0};
      up_left_win = '{default: '0};
      col_pos = 0;
      cur_filter = FILT_NONE;
      want_filter = 1'b1;
      top_row = 1'b1;
      store_fill = 0;
   endtask

   task automatic unfilter_byte(input logic [DATA_W-1:0] x, input logic start,
                                output bit produced, output unfiltered_byte_type res);
      int unsigned bpp, len;
      logic [DATA_W-1:0] a, b, c, v;
      logic [DATA_W:0] pair_sum;
      bpp = pixel_len();
      len = row_len();
      produced = 1'b0;
      res = '0;
      if (start) top_row = 1'b1;
      if (start || want_filter) begin
         cur_filter = (x <= 8'd4) ? filter_type'(x[2:0]) : FILT_NONE;
         left_win = '{default: '0};
         up_left_win = '{default: '0};
         col_pos = 0;
         want_filter = 1'b0;
         return;
      end
      b = top_row ? '0 : line_store[col_pos];
      if (col_pos >= bpp) begin
         a = left_win[bpp-1];
         c = up_left_win[bpp-1];
      end else begin
         a = '0;
         c = '0;
      end
      pair_sum = {1'b0, a} + {1'b0, b};
      case (cur_filter)
         FILT_SUB:   v = x + a;
         FILT_UP:    v = x + b;
         FILT_AVG:   v = x + pair_sum[DATA_W:1];
         FILT_PAETH: v = x + paeth_pick(a, b, c);
         default:    v = x;
      endcase
      line_store[col_pos] = v;
      if (col_pos + 1 > store_fill) store_fill = col_pos + 1;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
         left_win[i] = left_win[i-1];
         up_left_win[i] = up_left_win[i-1];
      end
      left_win[0] = v;
      up_left_win[0] = b;
      produced = 1'b1;
      res.pixel = v;
      res.column = col_pos[COL_W-1:0];
      if (col_pos + 1 >= len) begin
         res.row_end = 1'b1;
         col_pos = 0;
         want_filter = 1'b1;
         top_row = 1'b0;
      end else begin
         res.row_end = 1'b0;
         col_pos++;
      end
   endtask

   task automatic send_request(input logic [DATA_W-1:0] data, input logic start,
                               input bit known, input unfiltered_byte_type known_res);
      bit produced;
      unfiltered_byte_type res;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      unfilter_byte(data, start, produced, res);
      if (produced) expected_pixels.push_back(known ? known_res : res);
      gap = idle_gap(req_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers change only with the pipeline empty; filter bytes leave no
   // response behind, so the DRAIN_CYCLES wait covers one still in flight.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_ROW_BYTES:   cfg_row_bytes = value;
         CSR_PIXEL_BYTES: cfg_pixel_bytes = value[PIXEL_BYTES_W-1:0];
         default:         ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_row(input logic [DATA_W-1:0] filter_code, input logic start,
                           input int count);
      send_request(filter_code, start, 1'b0, '0);
      repeat (count) send_request(pick_byte(), 1'b0, 1'b0, '0);
   endtask

   task automatic run_phase(input int count);
      logic [DATA_W-1:0] data;
      logic start;
      repeat (count) begin
         if (want_filter) begin
            if ($urandom_range(0, 99) < 90) data = DATA_W'($urandom_range(FILT_NONE, FILT_PAETH));
            else data = DATA_W'($urandom_range(5, 255));
            start = ($urandom_range(0, 99) < 6);
         end else begin
            data = pick_byte();
            start = ($urandom_range(0, 99) < 2);
            // Never let a later row read a line store entry that was never written.
            if (!top_row && col_pos >= store_fill) start = 1'b1;
         end
         send_request(data, start, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin : rsp_monitor
      unfiltered_byte_type oldest;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("response with no request pending: pixel_byte %02h column %0d",
                   rsp_tdata[DATA_W-1:0], rsp_tdata[DATA_W +: COL_W]);
            error_count++;
         end else begin
            oldest = expected_pixels.pop_front();
            if (rsp_tdata[DATA_W-1:0] !== oldest.pixel) begin
               $error("pixel_byte: expected %02h, got %02h",
                      oldest.pixel, rsp_tdata[DATA_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[DATA_W +: COL_W] !== oldest.column) begin
               $error("column: expected %0d, got %0d",
                      oldest.column, rsp_tdata[DATA_W +: COL_W]);
               error_count++;
            end
            if (rsp_tlast !== oldest.row_end) begin
               $error("row_end: expected %0b, got %0b", oldest.row_end, rsp_tlast);
               error_count++;
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold = idle_gap(rsp_idle_on);
         rsp_tready <= (rsp_hold == 0);
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      script_step_type step;
      logic [CSR_DATA_W-1:0] row_pick;
      int roll;
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (bringup_script[i]) begin
         step = bringup_script[i];
         if (step.kind == STEP_WRITE) begin
            settle_idle();
            write_reg(step.sel, step.value);
         end else begin
            send_request(step.value[DATA_W-1:0], step.start, step.kind == STEP_SEND_KNOWN,
                         '{step.e_pixel, step.e_column, step.e_end});
         end
      end

      // Oversized row length and pixel size saturate to the maximum; the row
      // is left open and ends under the first phase's row length.
      settle_idle();
      write_reg(CSR_ROW_BYTES, '1);
      write_reg(CSR_PIXEL_BYTES, '1);
      send_row(DATA_W'(FILT_PAETH), 1'b1, OVERSIZE_REQUESTS);

      // Phases end wherever the count runs out, often in the middle of a row.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_idle();
         roll = $urandom_range(0, 99);
         if (roll < 15) row_pick = CSR_DATA_W'($urandom_range(0, 2));
         else if (roll < 90) row_pick = CSR_DATA_W'($urandom_range(3, 24));
         else row_pick = CSR_DATA_W'($urandom_range(25, 300));
         write_reg(CSR_ROW_BYTES, row_pick);
         write_reg(CSR_PIXEL_BYTES, CSR_DATA_W'($urandom_range(0, 15)));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         run_phase(PHASE_REQUESTS);
      end

      settle_idle();
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
